### rtl/core/wsd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types, header constants and the message kind encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

  // Position of the parser within the current frame.
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // Message kinds reported with the end of a message.
  typedef enum logic [1:0] {
    KIND_TEXT   = 2'd0,
    KIND_BINARY = 2'd1,
    KIND_CLOSE  = 2'd2,
    KIND_OTHER  = 2'd3
  } kind_t;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;

  // Seven-bit length codes that announce an extended length field.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Extended length and key byte counts, minus one.
  localparam logic [2:0] CNT_EXT16 = 3'd1;
  localparam logic [2:0] CNT_EXT64 = 3'd7;
  localparam logic [2:0] CNT_KEY   = 3'd3;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] out_byte;
    logic       msg_end;
    logic [1:0] msg_kind;
  } result_t;

  function automatic kind_t kind_of(input logic [3:0] op);
    kind_t k;
    if (op == OP_TEXT) begin
      k = KIND_TEXT;
    end else if (op == OP_BINARY) begin
      k = KIND_BINARY;
    end else if (op == OP_CLOSE) begin
      k = KIND_CLOSE;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

### rtl/core/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a received WebSocket byte stream and emits unmasked payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The receive channel (rx_valid, rx_stall, rx_byte) takes one stream byte
//   per transfer. Header bytes are consumed silently; each payload byte gives
//   one result with data_valid set and out_byte unmasked with the frame key.
//   The byte that completes a FIN frame also carries msg_end and msg_kind,
//   the kind taken from the opcode of the message's first frame. An empty
//   FIN frame ends on its last header byte with a result that has only
//   msg_end set.
//   The result channel (res_valid, res_stall) presents one result per
//   transfer. Each result is registered, in the result register or, while
//   that is held by a stall, in the skid register. Throughput is one byte
//   per cycle while rx_stall is low: the header parse and the 64-bit length
//   count are combinational up to the result register. A two-entry output
//   stage (result register plus skid register) absorbs a stall; rx_stall
//   rises only once both entries are full, and it is driven from a register.
//   Reset is synchronous; afterwards the block expects the first header byte
//   of a new message and holds no results.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_stall,
  input  wire logic [7:0] rx_byte,
  output logic            res_valid,
  input  wire logic       res_stall,
  output logic            data_valid,
  output logic [7:0]      out_byte,
  output logic            msg_end,
  output logic [1:0]      msg_kind
);

  // Parser state.
  phase_t      phase, phase_next;
  logic [2:0]  byte_cnt, byte_cnt_next;
  logic [63:0] remaining_len, remaining_len_next;
  logic [31:0] mask_key, mask_key_next;
  logic        mask_enabled, mask_enabled_next;
  logic [1:0]  key_index, key_index_next;
  logic [3:0]  message_opcode, message_opcode_next;
  logic        fin_seen, fin_seen_next;
  logic        first_frame, first_frame_next;
  logic        frame_end;

  // Output stage.
  result_t res_q, skid_q, result;
  logic    skid_valid;
  logic    res_has;
  logic    accept, take;
  logic [7:0] key_byte;
  logic [6:0] len7;
  logic [63:0] ext_len;

  assign accept = rx_valid && !rx_stall;
  assign take   = res_valid && !res_stall;
  assign len7   = rx_byte[6:0];
  assign ext_len = {remaining_len[55:0], rx_byte};

  // Next state of the parser.
  always_comb begin
    phase_next          = phase;
    byte_cnt_next       = byte_cnt;
    remaining_len_next  = remaining_len;
    mask_key_next       = mask_key;
    mask_enabled_next   = mask_enabled;
    key_index_next      = key_index;
    message_opcode_next = message_opcode;
    fin_seen_next       = fin_seen;
    first_frame_next    = first_frame;
    frame_end           = 1'b0;
    unique case (phase)
      PH_HDR0: begin
        fin_seen_next = rx_byte[7];
        if (first_frame) begin
          message_opcode_next = rx_byte[3:0];
          first_frame_next    = 1'b0;
        end
        key_index_next = 2'd0;
        phase_next     = PH_HDR1;
      end
      PH_HDR1: begin
        mask_enabled_next  = rx_byte[7];
        remaining_len_next = 64'd0;
        if (len7 == LEN_EXT16) begin
          byte_cnt_next = CNT_EXT16;
          phase_next    = PH_EXTLEN;
        end else if (len7 == LEN_EXT64) begin
          byte_cnt_next = CNT_EXT64;
          phase_next    = PH_EXTLEN;
        end else begin
          remaining_len_next = {57'd0, len7};
          if (rx_byte[7]) begin
            phase_next    = PH_KEY;
            byte_cnt_next = CNT_KEY;
            mask_key_next = 32'd0;
          end else if (len7 == 7'd0) begin
            frame_end  = 1'b1;
            phase_next = PH_HDR0;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_EXTLEN: begin
        remaining_len_next = ext_len;
        if (byte_cnt == 3'd0) begin
          if (mask_enabled) begin
            phase_next    = PH_KEY;
            byte_cnt_next = CNT_KEY;
            mask_key_next = 32'd0;
          end else if (ext_len == 64'd0) begin
            frame_end  = 1'b1;
            phase_next = PH_HDR0;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end else begin
          byte_cnt_next = byte_cnt - 3'd1;
        end
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], rx_byte};
        if (byte_cnt == 3'd0) begin
          key_index_next = 2'd0;
          if (remaining_len == 64'd0) begin
            frame_end  = 1'b1;
            phase_next = PH_HDR0;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end else begin
          byte_cnt_next = byte_cnt - 3'd1;
        end
      end
      PH_PAYLOAD: begin
        key_index_next     = key_index + 2'd1;
        remaining_len_next = remaining_len - 64'd1;
        if (remaining_len == 64'd1) begin
          frame_end  = 1'b1;
          phase_next = PH_HDR0;
        end
      end
      default: begin
        phase_next = PH_HDR0;
      end
    endcase
    // A frame with FIN set closes the message; the next frame starts a new one.
    if (frame_end && fin_seen) begin
      first_frame_next = 1'b1;
    end
  end

  // Key byte 0 is the first key byte received, now in the top byte.
  always_comb begin
    unique case (key_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // Result of the current byte.
  always_comb begin
    result = '0;
    if (phase == PH_PAYLOAD) begin
      result.data_valid = 1'b1;
      result.out_byte   = mask_enabled ? (rx_byte ^ key_byte) : rx_byte;
    end
    if (frame_end && fin_seen) begin
      result.msg_end  = 1'b1;
      result.msg_kind = kind_of(message_opcode);
    end
    res_has = result.data_valid || result.msg_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR0;
      byte_cnt       <= 3'd0;
      remaining_len  <= 64'd0;
      mask_key       <= 32'd0;
      mask_enabled   <= 1'b0;
      key_index      <= 2'd0;
      message_opcode <= 4'd0;
      fin_seen       <= 1'b0;
      first_frame    <= 1'b1;
    end else if (accept) begin
      phase          <= phase_next;
      byte_cnt       <= byte_cnt_next;
      remaining_len  <= remaining_len_next;
      mask_key       <= mask_key_next;
      mask_enabled   <= mask_enabled_next;
      key_index      <= key_index_next;
      message_opcode <= message_opcode_next;
      fin_seen       <= fin_seen_next;
      first_frame    <= first_frame_next;
    end
  end

  // The skid entry fills only while the result register is held by a stall,
  // and it refills the result register before anything new is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || take) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= accept && res_has;
      end
    end else if (accept && res_has) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || take) begin
      if (skid_valid) begin
        res_q <= skid_q;
      end else if (accept && res_has) begin
        res_q <= result;
      end
    end else if (accept && res_has) begin
      skid_q <= result;
    end
  end

  assign rx_stall   = skid_valid;
  assign data_valid = res_q.data_valid;
  assign out_byte   = res_q.out_byte;
  assign msg_end    = res_q.msg_end;
  assign msg_kind   = res_q.msg_kind;

endmodule

`default_nettype wire

### rtl/core/wsd_checker.sv
// ----------------------------------------------------------------------------
// WebSocket deframer port checker
// Watches the deframer's ports for consistent results over time.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rx_stall,
  input wire logic       res_valid,
  input wire logic       res_stall,
  input wire logic       data_valid,
  input wire logic [7:0] out_byte,
  input wire logic       msg_end,
  input wire logic [1:0] msg_kind
);

  // Reset leaves no results pending and the receive side open.
  property p_reset_empty;
    @(posedge clk) rst |=> (!res_valid && !rx_stall);
  endproperty
  a_reset_empty: assert property (p_reset_empty)
    else $error("results pending after reset");

  // A transfer always carries a payload byte or a message end.
  property p_not_empty;
    @(posedge clk) disable iff (rst) res_valid |-> (data_valid || msg_end);
  endproperty
  a_not_empty: assert property (p_not_empty)
    else $error("result carries neither data nor message end");

  property p_kind_idle;
    @(posedge clk) disable iff (rst) (res_valid && !msg_end) |-> (msg_kind == 2'd0);
  endproperty
  a_kind_idle: assert property (p_kind_idle)
    else $error("message kind set without message end");

  property p_byte_idle;
    @(posedge clk) disable iff (rst) (res_valid && !data_valid) |-> (out_byte == 8'd0);
  endproperty
  a_byte_idle: assert property (p_byte_idle)
    else $error("out_byte set without payload data");

  property p_hold;
    @(posedge clk) disable iff (rst)
      (res_valid && res_stall) |=>
        (res_valid && $stable(out_byte) && $stable(msg_end) && $stable(msg_kind));
  endproperty
  a_hold: assert property (p_hold)
    else $error("stalled result changed");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk        (clk),
  .rst        (rst),
  .rx_stall   (rx_stall),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .data_valid (data_valid),
  .out_byte   (out_byte),
  .msg_end    (msg_end),
  .msg_kind   (msg_kind)
);

`default_nettype wire

### test/tb_websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// Testbench for the WebSocket frame deframer
// Feeds a byte stream of directed and random frames (short, 16-bit and 64-bit
// lengths, masked and unmasked, fragmented messages) under changing flow
// control, and checks every result against a behavioral parser of the stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_websocket_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    result_t    r;
  } row_t;

  localparam result_t NO_RESULT = '0;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic       data_valid;
  logic [7:0] out_byte;
  logic       msg_end;
  logic [1:0] msg_kind;

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int results_seen = 0;
  int ends_seen = 0;

  result_t pending_results[$];

  // Parser state mirrored by the predictor.
  phase_t      st_phase = PH_HDR0;
  logic [2:0]  st_count = '0;
  logic [63:0] st_remain = '0;
  logic [31:0] st_key = '0;
  logic        st_masked = 1'b0;
  logic [1:0]  st_kidx = '0;
  logic [3:0]  st_opcode = '0;
  logic        st_fin = 1'b0;
  logic        st_first = 1'b1;

  int idle_mix[4] = '{0, 57, 0, 6};
  int stall_mix[4] = '{0, 0, 57, 6};

  row_t dir_rows[21] = '{
    // Empty text frame, unmasked, ends on its length byte.
    '{8'h81, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{1'b0, 8'h00, 1'b1, KIND_TEXT}},
    // Empty close frame with a key; parsing carries on afterwards.
    '{8'h88, 1'b0, NO_RESULT},
    '{8'h80, 1'b0, NO_RESULT},
    '{8'h12, 1'b0, NO_RESULT},
    '{8'h34, 1'b0, NO_RESULT},
    '{8'h56, 1'b0, NO_RESULT},
    '{8'h78, 1'b1, '{1'b0, 8'h00, 1'b1, KIND_CLOSE}},
    // Binary start without FIN, one masked byte.
    '{8'h02, 1'b0, NO_RESULT},
    '{8'h81, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{8'hA5, 1'b0, NO_RESULT},
    '{8'h5A, 1'b0, NO_RESULT},
    '{8'h3C, 1'b0, NO_RESULT},
    // A ping with RSV bits set closes the fragmented message as binary.
    '{8'hF9, 1'b0, NO_RESULT},
    '{8'h02, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{1'b1, 8'h00, 1'b0, KIND_TEXT}},
    '{8'hFF, 1'b1, '{1'b1, 8'hFF, 1'b1, KIND_BINARY}},
    // Unknown opcode reports as other.
    '{8'h8F, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, '{1'b0, 8'h00, 1'b1, KIND_OTHER}}
  };

  websocket_frame_deframer i_dut (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .data_valid (data_valid),
    .out_byte   (out_byte),
    .msg_end    (msg_end),
    .msg_kind   (msg_kind)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  function automatic bit close_frame();
    st_phase = PH_HDR0;
    if (st_fin) begin
      st_first = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit length_known();
    if (st_masked) begin
      st_phase = PH_KEY;
      st_count = CNT_KEY;
      st_key = '0;
      return 1'b0;
    end
    if (st_remain == 64'd0) begin
      return close_frame();
    end
    st_phase = PH_PAYLOAD;
    return 1'b0;
  endfunction

  // Advances the parser by one stream byte and gives the result it causes.
  function automatic void deframe_byte(input logic [7:0] b, output bit has,
                                       output result_t r);
    bit done;
    r = '0;
    done = 1'b0;
    case (st_phase)
      PH_HDR0: begin
        st_fin = b[7];
        if (st_first) begin
          st_opcode = b[3:0];
          st_first = 1'b0;
        end
        st_kidx = '0;
        st_phase = PH_HDR1;
      end
      PH_HDR1: begin
        st_masked = b[7];
        st_remain = '0;
        if (b[6:0] == LEN_EXT16) begin
          st_count = CNT_EXT16;
          st_phase = PH_EXTLEN;
        end else if (b[6:0] == LEN_EXT64) begin
          st_count = CNT_EXT64;
          st_phase = PH_EXTLEN;
        end else begin
          st_remain = 64'(b[6:0]);
          done = length_known();
        end
      end
      PH_EXTLEN: begin
        st_remain = {st_remain[55:0], b};
        if (st_count == 3'd0) begin
          done = length_known();
        end else begin
          st_count = st_count - 3'd1;
        end
      end
      PH_KEY: begin
        st_key = {st_key[23:0], b};
        if (st_count == 3'd0) begin
          st_kidx = '0;
          if (st_remain == 64'd0) begin
            done = close_frame();
          end else begin
            st_phase = PH_PAYLOAD;
          end
        end else begin
          st_count = st_count - 3'd1;
        end
      end
      default: begin
        // The first key byte received lines up with payload offset zero.
        r.data_valid = 1'b1;
        r.out_byte = st_masked ? (b ^ st_key[8 * (3 - st_kidx) +: 8]) : b;
        st_kidx = st_kidx + 2'd1;
        st_remain = st_remain - 64'd1;
        if (st_remain == 64'd0) begin
          done = close_frame();
        end
      end
    endcase
    if (done) begin
      r.msg_end = 1'b1;
      case (st_opcode)
        OP_TEXT:   r.msg_kind = KIND_TEXT;
        OP_BINARY: r.msg_kind = KIND_BINARY;
        OP_CLOSE:  r.msg_kind = KIND_CLOSE;
        default:   r.msg_kind = KIND_OTHER;
      endcase
    end
    has = r.data_valid | done;
  endfunction

  // Presents one byte, with random gaps before it, and waits for the transfer.
  task automatic xfer(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (rx_stall) begin
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  task automatic feed(input logic [7:0] b);
    bit has;
    result_t r;
    xfer(b);
    deframe_byte(b, has, r);
    if (has) begin
      pending_results.push_back(r);
    end
  endtask

  // Always lets the clock tick before it checks the queue, so the idle valid takes effect.
  task automatic drain();
    rx_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_results.size() != 0);
  endtask

  task automatic send_frame(input logic [3:0] op, input bit fin);
    logic [7:0]  hdr0;
    logic [7:0]  hdr1;
    logic [63:0] len;
    logic [31:0] key;
    bit          masked;
    int          mode;
    hdr0 = {fin, ($urandom_range(3) == 0) ? 3'($urandom) : 3'b000, op};
    masked = ($urandom_range(9) < 7);
    len = ($urandom_range(7) == 0) ? 64'($urandom_range(125, 13))
                                   : 64'($urandom_range(12, 0));
    mode = $urandom_range(9);
    // Now and then a header byte of pure noise.
    if ($urandom_range(9) == 0) begin
      hdr0 = 8'($urandom);
      mode = 0;
    end
    if (mode >= 6 && $urandom_range(5) == 0) begin
      len = 64'($urandom_range(300, 126));
    end
    hdr1 = {masked, (mode >= 8) ? LEN_EXT64 : (mode >= 6) ? LEN_EXT16 : len[6:0]};
    feed(hdr0);
    feed(hdr1);
    if (mode >= 6) begin
      for (int i = (mode >= 8) ? 7 : 1; i >= 0; i--) begin
        feed(len[8 * i +: 8]);
      end
    end
    if (masked) begin
      key = $urandom;
      for (int i = 3; i >= 0; i--) begin
        feed(key[8 * i +: 8]);
      end
    end
    for (longint n = 0; n < longint'(len); n++) begin
      feed(8'($urandom));
    end
    frames_sent++;
  endtask

  task automatic send_message();
    logic [3:0] op;
    int         nfr;
    case ($urandom_range(5))
      0, 4:    op = OP_TEXT;
      1, 5:    op = OP_BINARY;
      2:       op = OP_CLOSE;
      default: op = 4'($urandom);
    endcase
    nfr = ($urandom_range(3) == 0) ? $urandom_range(4, 2) : 1;
    for (int f = 0; f < nfr; f++) begin
      // Later fragments are continuations, with a control frame mixed in now and then.
      send_frame((f == 0) ? op : (($urandom_range(4) == 0) ? {1'b1, 3'($urandom)} : 4'h0),
                 f == nfr - 1);
    end
  endtask

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (msg_end) begin
        ends_seen++;
      end
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: data_valid %0b out_byte %02h msg_end %0b",
                                  data_valid, out_byte, msg_end));
      end else begin
        want = pending_results.pop_front();
        if (data_valid !== want.data_valid) begin
          report_mismatch($sformatf("data_valid %0b, want %0b", data_valid, want.data_valid));
        end
        if (out_byte !== want.out_byte) begin
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.out_byte));
        end
        if (msg_end !== want.msg_end) begin
          report_mismatch($sformatf("msg_end %0b, want %0b", msg_end, want.msg_end));
        end
        if (msg_kind !== want.msg_kind) begin
          report_mismatch($sformatf("msg_kind %0d, want %0d", msg_kind, want.msg_kind));
        end
      end
    end
  end

  initial begin
    bit      has;
    result_t r;
    int      waited;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      xfer(dir_rows[i].b);
      deframe_byte(dir_rows[i].b, has, r);
      if (dir_rows[i].typed) begin
        has = 1'b1;
        r = dir_rows[i].r;
      end
      if (has) begin
        pending_results.push_back(r);
      end
    end
    drain();

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_mix[p];
      stall_pct = stall_mix[p];
      while (bytes_sent < 21 + (p + 1) * 375) begin
        send_message();
      end
      drain();
    end

    // A 64-bit length with its top bit set is a plain count, so this frame never ends.
    feed({1'b1, 3'b000, OP_BINARY});
    feed({1'b1, LEN_EXT64});
    feed(8'h80);
    repeat (6) feed(8'h00);
    feed(8'h18);
    repeat (4) feed(8'($urandom));
    repeat (24) feed(8'($urandom));
    rx_valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));
    end

    $display("Checked %0d results, %0d of them message ends, from %0d bytes in %0d frames.",
             results_seen, ends_seen, bytes_sent, frames_sent);
    $display("Flow control ran free, with sender gaps, with receiver stalls, then lightly mixed.");
    if (errors == 0) begin
      $display("PASS websocket_frame_deframer");
    end else begin
      $display("FAIL websocket_frame_deframer");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(6_000_000);
    $display("FAIL websocket_frame_deframer");
    $finish;
  end

endmodule

`default_nettype wire

### websocket_frame_deframer.f
rtl/core/wsd_pkg.sv
rtl/core/websocket_frame_deframer.sv
rtl/core/wsd_checker.sv
test/tb_websocket_frame_deframer.sv
